>>> hdl/fys_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fys_pkg;

    // Store depth default and fixed field widths.
    localparam int DEPTH_DEF = 256;
    localparam int DATA_W    = 32;
    localparam int RAND_W    = 31;
    localparam int CMD_W     = 2;
    localparam int ST_W      = 2;

    // Command codes carried by each input item.
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STEP  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

    // Status codes returned with each result item.
    localparam logic [ST_W-1:0] ST_DONE   = 2'd0;
    localparam logic [ST_W-1:0] ST_REJECT = 2'd1;
    localparam logic [ST_W-1:0] ST_NOSTEP = 2'd2;
    localparam logic [ST_W-1:0] ST_EMPTY  = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic            clear;
        logic            load;
        logic            step_init;
        logic            div_start;
        logic            div_run;
        logic            rd_item;
        logic            rd_cursor;
        logic            rd_n;
        logic            wr_cursor;
        logic            wr_n;
        logic            dec_cursor;
        logic            set_st;
        logic [ST_W-1:0] st;
        logic            out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_zero;
        logic full;
        logic started;
        logic eff_zero;
        logic div_done;
        logic n_eq_cursor;
        logic slot_free;
    } t_dp_sts;

endpackage

`default_nettype wire

>>> hdl/fisher_yates_shuffle_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake          Payload
// input    in         i_valid, o_stall   i_cmd, i_element_value, i_rand_first, i_rand_second
// output   out        o_valid, i_stall   o_read_data, o_status, o_shuffle_finished
//
// Clear, load and read items, and steps with nothing to swap, go from acceptance through
// S_FIN to the result register, and no new item is taken until that result is loaded.
// A shuffle step with a swap is accepted, then runs in the bit-serial remainder unit
// (31 restoring steps, one quotient bit per cycle, and a decision), then uses the
// single read and single write port of the element store in S_RDA, S_RDB, S_WRA and
// S_WRB, and then loads the result; a step whose drawn index equals the cursor skips them.
// Reset is synchronous and active low; the store contents are not cleared.
// A result held by i_stall keeps the next item in its final state until the result leaves.

module fisher_yates_shuffle_engine
    import fys_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [CMD_W-1:0]  i_cmd,
    input  wire logic [DATA_W-1:0] i_element_value,
    input  wire logic [RAND_W-1:0] i_rand_first,
    input  wire logic [RAND_W-1:0] i_rand_second,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [DATA_W-1:0]      o_read_data,
    output logic [ST_W-1:0]        o_status,
    output logic                   o_shuffle_finished
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Sequencer for commands and the swap.
    fys_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_cmd   (i_cmd),
        .i_sts   (w_sts),
        .o_stall (o_stall),
        .o_cmd   (w_cmd)
    );

    // Store, divider and result register.
    fys_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .i_element_value    (i_element_value),
        .i_rand_first       (i_rand_first),
        .i_rand_second      (i_rand_second),
        .i_stall            (i_stall),
        .o_sts              (w_sts),
        .o_valid            (o_valid),
        .o_read_data        (o_read_data),
        .o_status           (o_status),
        .o_shuffle_finished (o_shuffle_finished)
    );

endmodule

`default_nettype wire

>>> hdl/fys_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module fys_ctrl
    import fys_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [CMD_W-1:0] i_cmd,
    input  wire t_dp_sts          i_sts,
    output logic                  o_stall,
    output t_dp_cmd               o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_RDA  = 3'd2;
    localparam logic [2:0] S_RDB  = 3'd3;
    localparam logic [2:0] S_WRA  = 3'd4;
    localparam logic [2:0] S_WRB  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Items are taken only while no earlier item is in progress.
    assign o_stall = (r_state != S_IDLE);

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.set_st = 1'b1;
                    n_state      = S_FIN;
                    unique case (i_cmd)
                        CMD_CLEAR: begin
                            o_cmd.clear = 1'b1;
                            o_cmd.st    = ST_DONE;
                        end
                        CMD_LOAD: begin
                            if (i_sts.full || i_sts.started) begin
                                o_cmd.st = ST_REJECT;
                            end else begin
                                o_cmd.load = 1'b1;
                                o_cmd.st   = ST_DONE;
                            end
                        end
                        CMD_STEP: begin
                            if (i_sts.count_zero) begin
                                o_cmd.st = ST_EMPTY;
                            end else begin
                                o_cmd.step_init = 1'b1;
                                o_cmd.div_start = 1'b1;
                                if (i_sts.eff_zero) begin
                                    o_cmd.st = ST_NOSTEP;
                                end else begin
                                    o_cmd.st = ST_DONE;
                                    n_state  = S_DIV;
                                end
                            end
                        end
                        CMD_READ: begin
                            if (i_sts.count_zero) begin
                                o_cmd.st = ST_EMPTY;
                            end else begin
                                o_cmd.rd_item = 1'b1;
                                o_cmd.st      = ST_DONE;
                            end
                        end
                        default: begin
                            o_cmd.st = ST_DONE;
                        end
                    endcase
                end
            end
            S_DIV: begin
                o_cmd.div_run = 1'b1;
                if (i_sts.div_done) begin
                    if (i_sts.n_eq_cursor) begin
                        o_cmd.dec_cursor = 1'b1;
                        n_state          = S_FIN;
                    end else begin
                        n_state = S_RDA;
                    end
                end
            end
            S_RDA: begin
                o_cmd.rd_cursor = 1'b1;
                n_state         = S_RDB;
            end
            S_RDB: begin
                o_cmd.rd_n = 1'b1;
                n_state    = S_WRA;
            end
            S_WRA: begin
                o_cmd.wr_cursor = 1'b1;
                n_state         = S_WRB;
            end
            S_WRB: begin
                o_cmd.wr_n       = 1'b1;
                o_cmd.dec_cursor = 1'b1;
                n_state          = S_FIN;
            end
            S_FIN: begin
                if (i_sts.slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

>>> hdl/fys_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module fys_dp
    import fys_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_cmd,
    input  wire logic [DATA_W-1:0] i_element_value,
    input  wire logic [RAND_W-1:0] i_rand_first,
    input  wire logic [RAND_W-1:0] i_rand_second,
    input  wire logic              i_stall,
    output t_dp_sts                o_sts,
    output logic                   o_valid,
    output logic [DATA_W-1:0]      o_read_data,
    output logic [ST_W-1:0]        o_status,
    output logic                   o_shuffle_finished
);

    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int DCW = $clog2(RAND_W + 1);

    // Element store and its registered read port.
    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;
    logic [DATA_W-1:0] r_tmp;

    // Bookkeeping registers.
    logic [CW-1:0] r_count;
    logic [AW-1:0] r_cursor;
    logic [AW-1:0] r_rpos;
    logic          r_started;

    // Divider registers.
    logic [CW-1:0]     r_div_d;
    logic [CW-1:0]     r_rem;
    logic [RAND_W-1:0] r_dvd;
    logic [DCW-1:0]    r_div_cnt;

    // Result registers.
    logic [ST_W-1:0]   r_status;
    logic              r_is_read;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;
    logic [ST_W-1:0]   r_out_st;
    logic              r_out_fin;

    logic [CW-1:0]     w_cnt_m1;
    logic [AW-1:0]     w_eff;
    logic [AW-1:0]     w_n;
    logic [RAND_W-1:0] w_rand;
    logic [CW:0]       w_trial;
    logic [CW:0]       w_diff;
    logic              w_ge;
    logic [AW-1:0]     w_rpos_eff;
    logic [CW-1:0]     w_rp_inc;
    logic              w_re;
    logic [AW-1:0]     w_raddr;
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [DATA_W-1:0] w_wdata;

    // Effective cursor: the first step starts from the last loaded element.
    assign w_cnt_m1 = r_count - CW'(1);
    assign w_eff    = r_started ? r_cursor : w_cnt_m1[AW-1:0];
    assign w_n      = r_rem[AW-1:0];

    // Random value: high half of the first word, top bits of the second below.
    assign w_rand = {i_rand_first[RAND_W-1:16], 1'b0, i_rand_second[RAND_W-1:16]};

    // One restoring division step per cycle.
    assign w_trial = {r_rem, r_dvd[RAND_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div_d});
    assign w_diff  = w_trial - {1'b0, r_div_d};

    // Read position wraps to zero past the last element.
    assign w_rpos_eff = ({{(CW-AW){1'b0}}, r_rpos} >= r_count) ? '0 : r_rpos;
    assign w_rp_inc   = {{(CW-AW){1'b0}}, w_rpos_eff} + CW'(1);

    // Memory port selection.
    assign w_re = i_cmd.rd_item | i_cmd.rd_cursor | i_cmd.rd_n;
    always_comb begin
        if (i_cmd.rd_cursor) begin
            w_raddr = r_cursor;
        end else if (i_cmd.rd_n) begin
            w_raddr = w_n;
        end else begin
            w_raddr = w_rpos_eff;
        end
    end

    assign w_we = i_cmd.load | i_cmd.wr_cursor | i_cmd.wr_n;
    always_comb begin
        if (i_cmd.wr_cursor) begin
            w_waddr = r_cursor;
            w_wdata = r_rd_data;
        end else if (i_cmd.wr_n) begin
            w_waddr = w_n;
            w_wdata = r_tmp;
        end else begin
            w_waddr = r_count[AW-1:0];
            w_wdata = i_element_value;
        end
    end

    // Element store.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd_data <= r_mem[w_raddr];
        end
        if (i_cmd.rd_n) begin
            r_tmp <= r_rd_data;
        end
    end

    // Count, cursor, read position and started flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_cursor  <= '0;
            r_rpos    <= '0;
            r_started <= 1'b0;
        end else if (i_cmd.clear) begin
            r_count   <= '0;
            r_cursor  <= '0;
            r_rpos    <= '0;
            r_started <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.step_init && !r_started) begin
                r_started <= 1'b1;
                r_cursor  <= w_cnt_m1[AW-1:0];
            end
            if (i_cmd.dec_cursor) begin
                r_cursor <= r_cursor - AW'(1);
            end
            if (i_cmd.rd_item) begin
                r_rpos <= (w_rp_inc >= r_count) ? '0 : w_rp_inc[AW-1:0];
            end
        end
    end

    // Divider: remainder of the random value by cursor plus one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_start) begin
            r_div_cnt <= DCW'(RAND_W);
        end else if (i_cmd.div_run && r_div_cnt != '0) begin
            r_div_cnt <= r_div_cnt - DCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_div_d <= {{(CW-AW){1'b0}}, w_eff} + CW'(1);
            r_rem   <= '0;
            r_dvd   <= w_rand;
        end else if (i_cmd.div_run && r_div_cnt != '0) begin
            r_rem <= w_ge ? w_diff[CW-1:0] : w_trial[CW-1:0];
            r_dvd <= {r_dvd[RAND_W-2:0], 1'b0};
        end
    end

    // Status and kind of the item in progress.
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_st) begin
            r_status  <= i_cmd.st;
            r_is_read <= i_cmd.rd_item;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= r_is_read ? r_rd_data : '0;
            r_out_st   <= r_status;
            r_out_fin  <= r_started && (r_cursor == '0);
        end
    end

    // Status toward the controller.
    assign o_sts.count_zero  = (r_count == '0);
    assign o_sts.full        = (r_count == CW'(DEPTH));
    assign o_sts.started     = r_started;
    assign o_sts.eff_zero    = (w_eff == '0);
    assign o_sts.div_done    = (r_div_cnt == '0);
    assign o_sts.n_eq_cursor = (w_n == r_cursor);
    assign o_sts.slot_free   = !r_out_valid || !i_stall;

    assign o_valid            = r_out_valid;
    assign o_read_data        = r_out_data;
    assign o_status           = r_out_st;
    assign o_shuffle_finished = r_out_fin;

endmodule

`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import fys_pkg::*;

    localparam int          IDLE_LIMIT = 2000;
    localparam int          GRACE      = 64;
    localparam logic [31:0] HIGH_HALF  = 32'hFFFF0000;

    typedef struct {
        logic [DATA_W-1:0] data;
        logic [ST_W-1:0]   status;
        logic              fin;
    } t_engine_reply;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [CMD_W-1:0]  i_cmd;
    logic [DATA_W-1:0] i_element_value;
    logic [RAND_W-1:0] i_rand_first;
    logic [RAND_W-1:0] i_rand_second;
    logic              o_valid;
    logic              i_stall;
    logic [DATA_W-1:0] o_read_data;
    logic [ST_W-1:0]   o_status;
    logic              o_shuffle_finished;

    // Predicted state of the permutation engine.
    logic [DATA_W-1:0] perm_store [DEPTH_DEF];
    logic [8:0]        elem_count;
    logic [7:0]        swap_pos;
    logic [7:0]        read_pos;
    logic              shuffling;

    t_engine_reply engine_replies[$];
    int            errors;
    int            items_sent;
    int            idle_cycles;
    bit            quiet;

    fisher_yates_shuffle_engine #(
        .DEPTH(DEPTH_DEF)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_cmd              (i_cmd),
        .i_element_value    (i_element_value),
        .i_rand_first       (i_rand_first),
        .i_rand_second      (i_rand_second),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_read_data        (o_read_data),
        .o_status           (o_status),
        .o_shuffle_finished (o_shuffle_finished)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Applies one command to the predicted state and queues the reply it owes.
    task automatic apply_engine_cmd(input logic [CMD_W-1:0] cmd,
                                    input logic [DATA_W-1:0] value,
                                    input logic [RAND_W-1:0] rf,
                                    input logic [RAND_W-1:0] rs);
        t_engine_reply rep;
        logic [31:0]   rnd;
        logic [31:0]   idx;
        logic [31:0]   tmp;
        logic [8:0]    rd_next;
        rep.data   = '0;
        rep.status = ST_DONE;
        case (cmd)
            CMD_CLEAR: begin
                elem_count = '0;
                swap_pos   = '0;
                read_pos   = '0;
                shuffling  = 1'b0;
            end
            CMD_LOAD: begin
                if (elem_count >= DEPTH_DEF || shuffling) begin
                    rep.status = ST_REJECT;
                end else begin
                    perm_store[elem_count] = value;
                    elem_count = elem_count + 9'd1;
                end
            end
            CMD_STEP: begin
                if (elem_count == 0) begin
                    rep.status = ST_EMPTY;
                end else begin
                    // The first step after a clear places the cursor on the last entry.
                    if (!shuffling) begin
                        shuffling = 1'b1;
                        swap_pos  = 8'(elem_count - 9'd1);
                    end
                    if (swap_pos == 0) begin
                        rep.status = ST_NOSTEP;
                    end else begin
                        rnd = ({1'b0, rf} & HIGH_HALF) | ({1'b0, rs} >> 16);
                        idx = rnd % ({24'd0, swap_pos} + 32'd1);
                        if (idx != {24'd0, swap_pos}) begin
                            tmp                  = perm_store[swap_pos];
                            perm_store[swap_pos] = perm_store[idx[7:0]];
                            perm_store[idx[7:0]] = tmp;
                        end
                        swap_pos = swap_pos - 8'd1;
                    end
                end
            end
            CMD_READ: begin
                if (elem_count == 0) begin
                    rep.status = ST_EMPTY;
                end else begin
                    if ({1'b0, read_pos} >= elem_count) read_pos = '0;
                    rep.data = perm_store[read_pos];
                    rd_next  = {1'b0, read_pos} + 9'd1;
                    read_pos = (rd_next >= elem_count) ? 8'd0 : rd_next[7:0];
                end
            end
            default: ;
        endcase
        rep.fin = shuffling && swap_pos == 0;
        engine_replies.push_back(rep);
    endtask

    // Drives one item, holds it until the block takes it, then predicts its reply.
    task automatic send_item(input logic [CMD_W-1:0] cmd,
                             input logic [DATA_W-1:0] value,
                             input logic [RAND_W-1:0] rf,
                             input logic [RAND_W-1:0] rs);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 11);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_cmd           <= cmd;
        i_element_value <= value;
        i_rand_first    <= rf;
        i_rand_second   <= rs;
        i_valid         <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        apply_engine_cmd(cmd, value, rf, rs);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Random word with the extremes drawn now and then.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_cmd(input logic [CMD_W-1:0] cmd);
        send_item(cmd, pick_word(), RAND_W'(pick_word()), RAND_W'(pick_word()));
    endtask

    // Holds the sender off until every owed reply has come back.
    task automatic wait_replies_drained();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (engine_replies.size() != 0) @(negedge i_clk);
    endtask

    // Commands on an empty store.
    task automatic test_empty_store();
        send_cmd(CMD_CLEAR);
        send_cmd(CMD_READ);
        send_cmd(CMD_STEP);
    endtask

    // One element: the first step has nothing to swap and loads are then refused.
    task automatic test_single_element();
        send_item(CMD_LOAD, 32'hFFFF_FFFF, '0, '0);
        send_cmd(CMD_READ);
        send_item(CMD_STEP, '1, '1, '1);
        send_cmd(CMD_STEP);
        send_item(CMD_LOAD, 32'h0000_0000, '0, '0);
        send_cmd(CMD_READ);
    endtask

    // Field extremes, a swap with itself, a swap with entry zero and read wrap.
    task automatic test_field_extremes();
        send_cmd(CMD_CLEAR);
        send_item(CMD_LOAD, 32'h0000_0000, '0, '0);
        send_item(CMD_LOAD, 32'hFFFF_FFFF, '1, '1);
        send_item(CMD_LOAD, 32'hA5C3_0F96, '0, '1);
        send_item(CMD_STEP, '0, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        // A random value of one lands on cursor one, so the entry swaps with itself.
        send_item(CMD_STEP, '0, 31'h0000_0000, 31'h0001_0000);
        send_item(CMD_STEP, '0, '1, '1);
        repeat (4) send_cmd(CMD_READ);
        send_cmd(CMD_CLEAR);
        send_item(CMD_LOAD, 32'h1234_5678, '0, '0);
        send_item(CMD_LOAD, 32'h8765_4321, '0, '0);
        send_item(CMD_STEP, '0, 31'h0000_0000, 31'h0000_0000);
        repeat (2) send_cmd(CMD_READ);
    endtask

    // Fills the store, checks the refused load, shuffles a little and reads past the wrap.
    task automatic test_full_store();
        send_cmd(CMD_CLEAR);
        repeat (DEPTH_DEF) send_cmd(CMD_LOAD);
        send_cmd(CMD_LOAD);
        repeat (8) send_cmd(CMD_STEP);
        repeat (DEPTH_DEF + 2) send_cmd(CMD_READ);
    endtask

    // One shuffle session of k elements, sometimes broken by a missing clear or noise.
    task automatic run_session(input int k);
        int steps;
        if ($urandom_range(0, 7) != 0) send_cmd(CMD_CLEAR);
        for (int i = 0; i < k; i++) begin
            send_cmd(CMD_LOAD);
            if ($urandom_range(0, 7) == 0) send_cmd(CMD_READ);
        end
        steps = k - 1 + $urandom_range(0, 2);
        for (int i = 0; i < steps; i++) begin
            send_cmd(CMD_STEP);
            if ($urandom_range(0, 5) == 0) send_cmd(CMD_READ);
            if ($urandom_range(0, 11) == 0) send_cmd(CMD_LOAD);
        end
        repeat (k + $urandom_range(0, 3)) send_cmd(CMD_READ);
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6)) send_cmd(CMD_W'(CMD_CLEAR + $urandom_range(0, 3)));
        end
    endtask

    function automatic int pick_size();
        case ($urandom_range(0, 19))
            0:       return $urandom_range(17, 64);
            1, 2, 3: return $urandom_range(9, 16);
            default: return $urandom_range(1, 8);
        endcase
    endfunction

    // Random sessions with idling on both sides.
    task automatic test_random_sessions();
        while (items_sent < 890) begin
            run_session(pick_size());
            if ($urandom_range(0, 9) == 0) wait_replies_drained();
        end
    endtask

    // Back-to-back sessions with no idling at all.
    task automatic test_quiet_tail();
        quiet = 1'b1;
        repeat (3) run_session($urandom_range(2, 8));
    endtask

    // Receiver stall in random bursts; no new burst starts once the quiet tail begins.
    initial begin
        i_stall = 1'b0;
        wait (i_rst_n);
        forever begin
            repeat ($urandom_range(1, 30)) begin
                @(negedge i_clk);
                i_stall <= 1'b0;
            end
            if (!quiet) begin
                repeat ($urandom_range(1, 11)) begin
                    @(negedge i_clk);
                    i_stall <= 1'b1;
                end
            end
        end
    end

    // Compare each reply with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (engine_replies.size() == 0) begin
                $display("%0t: reply with none owed: read_data %h status %0d finished %0b",
                         $time, o_read_data, o_status, o_shuffle_finished);
                errors++;
            end else begin
                if (o_read_data !== engine_replies[0].data) begin
                    $display("%0t: read_data expected %h actual %h",
                             $time, engine_replies[0].data, o_read_data);
                    errors++;
                end
                if (o_status !== engine_replies[0].status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, engine_replies[0].status, o_status);
                    errors++;
                end
                if (o_shuffle_finished !== engine_replies[0].fin) begin
                    $display("%0t: shuffle_finished expected %0b actual %0b",
                             $time, engine_replies[0].fin, o_shuffle_finished);
                    errors++;
                end
                void'(engine_replies.pop_front());
            end
        end
    end

    // Watchdog on cycles where neither channel moves an item.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
                    $display("TB_ERROR");
                    $finish;
                end
            end
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_cmd           = CMD_CLEAR;
        i_element_value = '0;
        i_rand_first    = '0;
        i_rand_second   = '0;
        elem_count      = '0;
        swap_pos        = '0;
        read_pos        = '0;
        shuffling       = 1'b0;
        errors          = 0;
        items_sent      = 0;
        idle_cycles     = 0;
        quiet           = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_store();
        test_single_element();
        test_field_extremes();
        wait_replies_drained();
        test_full_store();
        wait_replies_drained();
        test_random_sessions();
        test_quiet_tail();

        wait_replies_drained();
        repeat (GRACE) @(posedge i_clk);
        if (errors == 0 && engine_replies.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
